// ===== rtl/core/bal_pkg.sv =====
// bal_pkg: shared constants, codes and helpers of the bounded array list
// depends on nothing; used by bounded_array_list
`default_nettype none

package bal_pkg;

    // list geometry
    localparam int LIST_DEPTH = 16;
    localparam int ENTRY_BITS = 32;

    // field widths fixed by the port list
    localparam int FUNC_W  = 3;
    localparam int POS_W   = 4;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int RDATA_W = 32;
    localparam int COUNT_W = 5;

    // derived widths
    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [ENTRY_BITS-1:0] entry_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CMP_W-1:0]      cmp_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR       = 3'd0,
        FN_INSERT      = 3'd1,
        FN_REMOVE_LAST = 3'd2,
        FN_REMOVE_AT   = 3'd3,
        FN_READ_START  = 3'd4,
        FN_READ_END    = 3'd5
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // low bits of the input word, zero above
    function automatic entry_t fit_word(input logic [VALUE_W-1:0] v);
        entry_t r;
        for (int i = 0; i < ENTRY_BITS; i++)
        begin
            r[i] = (i < VALUE_W) ? v[i] : 1'b0;
        end
        return r;
    endfunction

    // entry shown on the read data port
    function automatic logic [RDATA_W-1:0] show_word(input entry_t e);
        logic [RDATA_W-1:0] r;
        for (int i = 0; i < RDATA_W; i++)
        begin
            r[i] = (i < ENTRY_BITS) ? e[i] : 1'b0;
        end
        return r;
    endfunction

    // low bits of the entry count for the count port
    function automatic logic [COUNT_W-1:0] show_count(input cnt_t c);
        logic [COUNT_W-1:0] r;
        for (int i = 0; i < COUNT_W; i++)
        begin
            r[i] = (i < CNT_W) ? c[i] : 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bounded_array_list.sv =====
// bounded_array_list: fixed-capacity ordered list of data words, top level
// depends on bal_pkg and bal_ram
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------
//  in      | in_valid, in_stall | func, position, value
//  out     | out_valid, out_stall | status, read_data, count
//
// one request at a time; in_stall is low only while the sequencer is idle
// clear, remove last, unknown func and rejected requests go straight to done
// reads pass read and capture; insert and remove at p shift the entries behind p
// the shift loop reads, then writes, each entry through the single read port
// of the entry ram; a stalled result holds the sequencer in its final state
// rst_n clears the count and the sequencer; the entry ram holds no reset
`default_nettype none

module bounded_array_list
    import bal_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request side
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [POS_W-1:0]   position,
    input  wire logic [VALUE_W-1:0] value,
    // result side
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [STAT_W-1:0]       status,
    output logic [RDATA_W-1:0]      read_data,
    output logic [COUNT_W-1:0]      count
);

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SHIFT_RD = 7'b0000010,
        S_SHIFT_WR = 7'b0000100,
        S_PUT      = 7'b0001000,
        S_READ     = 7'b0010000,
        S_CAPTURE  = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    addr_t   idx_reg, idx_next;
    addr_t   limit_reg, limit_next;
    logic    up_reg, up_next;
    entry_t  word_reg, word_next;
    status_t stat_reg, stat_next;
    logic [RDATA_W-1:0] rd_reg, rd_next;

    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  out_stat_reg, out_stat_next;
    logic [RDATA_W-1:0] out_rd_reg, out_rd_next;
    logic [COUNT_W-1:0] out_cnt_reg, out_cnt_next;

    // ram ports
    logic   ram_we;
    addr_t  ram_waddr;
    entry_t ram_wdata;
    addr_t  ram_raddr;
    entry_t ram_rdata;

    // shared index unit: neighbor of the current slot
    addr_t src;

    // request decode helpers
    logic accept;
    logic out_free;
    cmp_t pos_c;
    cmp_t cnt_c;
    cmp_t cnt_m1;
    cmp_t ins_p;
    cmp_t rd_idx;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign pos_c  = CMP_W'(position);
    assign cnt_c  = CMP_W'(count_reg);
    assign cnt_m1 = cnt_c - CMP_W'(1);
    assign ins_p  = (pos_c > cnt_c) ? cnt_c : pos_c;
    assign rd_idx = (func_t'(func) == FN_READ_START) ? pos_c : (cnt_m1 - pos_c);

    // insert walks down from the tail, remove walks up from the hole
    assign src = up_reg ? (idx_reg - ADDR_W'(1)) : (idx_reg + ADDR_W'(1));

    // ram port muxing
    assign ram_we    = (state_reg == S_SHIFT_WR) || (state_reg == S_PUT);
    assign ram_waddr = (state_reg == S_PUT) ? limit_reg : idx_reg;
    assign ram_wdata = (state_reg == S_PUT) ? word_reg : ram_rdata;
    assign ram_raddr = (state_reg == S_READ) ? idx_reg : src;

    bal_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        limit_next = limit_reg;
        up_next    = up_reg;
        word_next  = word_reg;
        stat_next  = stat_reg;
        rd_next    = rd_reg;

        out_valid_next = out_valid_reg && out_stall;
        out_stat_next  = out_stat_reg;
        out_rd_next    = out_rd_reg;
        out_cnt_next   = out_cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    stat_next  = ST_OK;
                    rd_next    = '0;
                    word_next  = fit_word(value);
                    state_next = S_DONE;
                    case (func_t'(func))
                        FN_CLEAR:
                        begin
                            count_next = '0;
                        end
                        FN_INSERT:
                        begin
                            if (cnt_c >= CMP_W'(LIST_DEPTH))
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                // a position past the tail appends
                                idx_next   = cnt_c[ADDR_W-1:0];
                                limit_next = ins_p[ADDR_W-1:0];
                                up_next    = 1'b1;
                                state_next = (ins_p == cnt_c) ? S_PUT : S_SHIFT_RD;
                            end
                        end
                        FN_REMOVE_LAST:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        FN_REMOVE_AT:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else if (pos_c >= cnt_c)
                            begin
                                stat_next = ST_RANGE;
                            end
                            else if (pos_c == cnt_m1)
                            begin
                                // removing the tail needs no shift
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                idx_next   = pos_c[ADDR_W-1:0];
                                limit_next = cnt_m1[ADDR_W-1:0];
                                up_next    = 1'b0;
                                state_next = S_SHIFT_RD;
                            end
                        end
                        FN_READ_START, FN_READ_END:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = ST_EMPTY;
                            end
                            else if (pos_c >= cnt_c)
                            begin
                                stat_next = ST_RANGE;
                            end
                            else
                            begin
                                idx_next   = rd_idx[ADDR_W-1:0];
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            // unused codes: no change, status ok
                        end
                    endcase
                end
            end
            S_SHIFT_RD:
            begin
                // neighbor read is in flight
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                // neighbor lands in the current slot
                idx_next = src;
                if (src == limit_reg)
                begin
                    if (up_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_PUT:
            begin
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_READ:
            begin
                state_next = S_CAPTURE;
            end
            S_CAPTURE:
            begin
                rd_next    = show_word(ram_rdata);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for room in the result register
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_rd_next    = rd_reg;
                    out_cnt_next   = show_count(count_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        limit_reg    <= limit_next;
        up_reg       <= up_next;
        word_reg     <= word_next;
        stat_reg     <= stat_next;
        rd_reg       <= rd_next;
        out_stat_reg <= out_stat_next;
        out_rd_reg   <= out_rd_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_stat_reg;
    assign read_data = out_rd_reg;
    assign count     = out_cnt_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bal_ram.sv =====
// bal_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`default_nettype none

module bal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
